>>> rtl/calendar_to_epoch_seconds_assert.svh
// Assertion macros shared by the calendar-to-epoch checker.
`ifndef CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH
`define CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define CTES_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication form: when cond holds, expr must hold on the next edge.
`define CTES_ASSERT_NEXT(lbl, clk, rst, cond, expr, msg) \
   `CTES_ASSERT(lbl, clk, rst, (cond) |=> (expr), msg)

`endif

>>> rtl/ctes_pkg.sv
// Shared types, constants and tables for the calendar-to-epoch converter.
`default_nettype none
package ctes_pkg;

   localparam int BASE_YEAR     = 1970;
   localparam int DAYS_PER_YEAR = 365;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int OUT_W   = 38;
   localparam int ACC_W   = 41;   // signed accumulator, holds total before clamping
   localparam int DAYS_W  = 24;   // signed day count before scaling to seconds

   localparam logic [YEAR_W-1:0] BASE_YEAR_V = YEAR_W'(BASE_YEAR);
   localparam logic [1:0]        BASE_MOD4   = 2'(BASE_YEAR % 4);
   localparam logic [6:0]        BASE_MOD100 = 7'(BASE_YEAR % 100);
   localparam logic [8:0]        BASE_MOD400 = 9'(BASE_YEAR % 400);

   localparam logic signed [17:0] SECS_PER_DAY  = 18'sd86400;
   localparam logic [16:0]        SECS_PER_HOUR = 17'd3600;
   localparam logic [11:0]        SECS_PER_MIN  = 12'd60;
   localparam logic [OUT_W-1:0]   OUT_MAX       = {OUT_W{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_YEAR,
      ST_MONTH,
      ST_DAY,
      ST_MUL,
      ST_HOUR,
      ST_MIN,
      ST_SEC,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      ALU_HOLD,
      ALU_CLEAR,
      ALU_ADD,
      ALU_MUL
   } alu_op_type;

   typedef struct packed {
      alu_op_type              op;
      logic signed [ACC_W-1:0] addend;
   } alu_ctl_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   second;
   } fields_type;

   typedef struct packed {
      logic idle;
      logic done;
      logic before_base;
   } status_type;

   // Month length; zero and numbers past twelve count as February.
   function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
      logic [4:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         default:                                   len = 5'd28 + {4'd0, leap};
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

>>> rtl/ctes_alu.sv
// Shared accumulator: add, scale days to seconds, clear.
`default_nettype none
module ctes_alu (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ctes_pkg::alu_ctl_type            alu_ctl,
   output logic signed [ctes_pkg::ACC_W-1:0]     acc
);
   import ctes_pkg::*;

   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [DAYS_W-1:0]   days_s;
   logic signed [DAYS_W+17:0]  prod;

   assign days_s = signed'(acc_ff[DAYS_W-1:0]);
   assign prod   = days_s * SECS_PER_DAY;

   always_comb begin
      unique case (alu_ctl.op)
         ALU_HOLD:  acc_in = acc_ff;
         ALU_CLEAR: acc_in = '0;
         ALU_ADD:   acc_in = acc_ff + alu_ctl.addend;
         ALU_MUL:   acc_in = ACC_W'(prod);
         default:   acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;
endmodule
`default_nettype wire

>>> rtl/ctes_ctrl.sv
// Sequencer: steps years, months and time fields through the shared accumulator.
`default_nettype none
module ctes_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  out_free,
   input  wire ctes_pkg::fields_type  fields,
   output ctes_pkg::alu_ctl_type      alu_ctl,
   output ctes_pkg::status_type       status
);
   import ctes_pkg::*;

   state_type          state_ff, state_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [1:0]         mod4_ff, mod4_in;
   logic [6:0]         mod100_ff, mod100_in;
   logic [8:0]         mod400_ff, mod400_in;
   logic [MONTH_W-1:0] mon_ff, mon_in;
   logic               early_ff, early_in;
   logic               leap;

   // leap test on the year counter; after the year walk it is the input year
   assign leap = (mod400_ff == '0) || ((mod100_ff != '0) && (mod4_ff == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         year_ff   <= BASE_YEAR_V;
         mod4_ff   <= BASE_MOD4;
         mod100_ff <= BASE_MOD100;
         mod400_ff <= BASE_MOD400;
         mon_ff    <= 4'd1;
         early_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         year_ff   <= year_in;
         mod4_ff   <= mod4_in;
         mod100_ff <= mod100_in;
         mod400_ff <= mod400_in;
         mon_ff    <= mon_in;
         early_ff  <= early_in;
      end
   end

   always_comb begin
      state_in           = state_ff;
      year_in            = year_ff;
      mod4_in            = mod4_ff;
      mod100_in          = mod100_ff;
      mod400_in          = mod400_ff;
      mon_in             = mon_ff;
      early_in           = early_ff;
      alu_ctl.op         = ALU_HOLD;
      alu_ctl.addend     = '0;
      status.idle        = 1'b0;
      status.done        = 1'b0;
      status.before_base = early_ff;

      unique case (state_ff)
         ST_IDLE: begin
            status.idle = 1'b1;
            if (start) begin
               year_in    = BASE_YEAR_V;
               mod4_in    = BASE_MOD4;
               mod100_in  = BASE_MOD100;
               mod400_in  = BASE_MOD400;
               mon_in     = 4'd1;
               early_in   = 1'b0;
               alu_ctl.op = ALU_CLEAR;
               state_in   = ST_YEAR;
            end
         end
         ST_YEAR: begin
            priority if (fields.year < BASE_YEAR_V) begin
               early_in = 1'b1;
               state_in = ST_DONE;
            end else if (year_ff < fields.year) begin
               alu_ctl.op     = ALU_ADD;
               alu_ctl.addend = ACC_W'(DAYS_PER_YEAR) + ACC_W'(leap);
               year_in        = year_ff + 1'b1;
               mod4_in        = mod4_ff + 1'b1;
               mod100_in      = (mod100_ff == 7'd99)  ? '0 : mod100_ff + 1'b1;
               mod400_in      = (mod400_ff == 9'd399) ? '0 : mod400_ff + 1'b1;
            end else begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (mon_ff < fields.month) begin
               alu_ctl.op     = ALU_ADD;
               alu_ctl.addend = ACC_W'(month_len(mon_ff, leap));
               mon_in         = mon_ff + 1'b1;
            end else begin
               state_in = ST_DAY;
            end
         end
         ST_DAY: begin
            // day zero gives minus one
            alu_ctl.op     = ALU_ADD;
            alu_ctl.addend = ACC_W'(fields.day) - ACC_W'(1);
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            alu_ctl.op = ALU_MUL;
            state_in   = ST_HOUR;
         end
         ST_HOUR: begin
            alu_ctl.op     = ALU_ADD;
            alu_ctl.addend = ACC_W'({12'd0, fields.hour} * SECS_PER_HOUR);
            state_in       = ST_MIN;
         end
         ST_MIN: begin
            alu_ctl.op     = ALU_ADD;
            alu_ctl.addend = ACC_W'({6'd0, fields.minute} * SECS_PER_MIN);
            state_in       = ST_SEC;
         end
         ST_SEC: begin
            alu_ctl.op     = ALU_ADD;
            alu_ctl.addend = ACC_W'(fields.second);
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            status.done = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

>>> rtl/calendar_to_epoch_seconds.sv
// Top level: Gregorian date and time to seconds since January 1, 1970.
// Flow: a year walk (one accumulator add per elapsed year since 1970), a month
//   walk, the day, the scale to seconds, then hour, minute and second; a year
//   before 1970 skips straight to the result with before_base set.
// Throughput: one word at a time; req_tready returns the cycle after the
//   result is loaded into the output register.
// Reset: synchronous, active high; clears the sequencer and the output valid.
`default_nettype none
module calendar_to_epoch_seconds (
   input  wire logic        clock,
   input  wire logic        reset,
   // request word
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // year[13:0], month[17:14], day[22:18],
                                         // hour[27:23], minute[33:28], second[39:34]
   // result word
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // epoch_seconds[37:0], zero pad [39:38]
   output logic             rsp_tuser    // before_base
);
   import ctes_pkg::*;

   fields_type              fields_ff, fields_in;
   alu_ctl_type             alu_ctl;
   status_type              status;
   logic signed [ACC_W-1:0] acc;
   logic                    accept;
   logic                    out_free;
   logic                    load;
   logic [OUT_W-1:0]        clamped;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]        rsp_secs_ff, rsp_secs_in;
   logic                    rsp_flag_ff, rsp_flag_in;

   assign req_tready = status.idle;
   assign accept     = req_tvalid && req_tready;

   // unpack request word
   always_comb begin
      fields_in = fields_ff;
      if (accept) begin
         fields_in.year   = req_tdata[13:0];
         fields_in.month  = req_tdata[17:14];
         fields_in.day    = req_tdata[22:18];
         fields_in.hour   = req_tdata[27:23];
         fields_in.minute = req_tdata[33:28];
         fields_in.second = req_tdata[39:34];
      end
   end

   always_ff @(posedge clock) begin
      fields_ff <= fields_in;
   end

   ctes_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .out_free (out_free),
      .fields   (fields_ff),
      .alu_ctl  (alu_ctl),
      .status   (status)
   );

   ctes_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_ctl (alu_ctl),
      .acc     (acc)
   );

   // negative totals (day zero on the base date) clamp to zero, overflow to max
   always_comb begin
      priority if (acc[ACC_W-1]) begin
         clamped = '0;
      end else if (acc[ACC_W-2:0] > (ACC_W-1)'(OUT_MAX)) begin
         clamped = OUT_MAX;
      end else begin
         clamped = acc[OUT_W-1:0];
      end
   end

   // output register: holds the result while the sink stalls
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load     = status.done && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_secs_in  = rsp_secs_ff;
      rsp_flag_in  = rsp_flag_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_secs_in  = status.before_base ? '0 : clamped;
         rsp_flag_in  = status.before_base;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_secs_ff <= rsp_secs_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_secs_ff};
   assign rsp_tuser  = rsp_flag_ff;
endmodule
`default_nettype wire

>>> rtl/ctes_checker.sv
// Port-level checker for the calendar-to-epoch converter, bound to the top level.
`default_nettype none
`include "calendar_to_epoch_seconds_assert.svh"
module ctes_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [39:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tuser
);
   import ctes_pkg::*;

   logic [YEAR_W-1:0] req_year;

   assign req_year = req_tdata[YEAR_W-1:0];

   // ready is low in the cycle after an accepted word
   `CTES_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready,
                     !req_tready, "ready stayed high after accept")

   // early year reports zero seconds
   `CTES_ASSERT(a_early_zero, clock, reset,
                (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[37:0] == 38'd0),
                "before_base with nonzero seconds")

   // pad bits above the seconds field are zero
   `CTES_ASSERT(a_pad_zero, clock, reset, rsp_tvalid |-> (rsp_tdata[39:38] == 2'b00),
                "nonzero pad bits")

   // a stalled result holds
   `CTES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
                     "stalled result changed")

   // an early year is flagged after its short walk
   `CTES_ASSERT(a_early_flag, clock, reset,
                (req_tvalid && req_tready && (req_year < BASE_YEAR_V) && !rsp_tvalid)
                |-> ##3 (rsp_tvalid && rsp_tuser),
                "early year not flagged")

endmodule

bind calendar_to_epoch_seconds ctes_checker u_ctes_checker (.*);
`default_nettype wire
